[src/sfd_pkg.sv]
// Shared types and constants for the SLIP frame decoder.
package sfd_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int LEN_W = 7;
	localparam int BYTE_W = 8;

	localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(64);
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(STORE_DEPTH);

	localparam logic [BYTE_W-1:0] SYM_END = 8'hC0;
	localparam logic [BYTE_W-1:0] SYM_ESC = 8'hDB;
	localparam logic [BYTE_W-1:0] SYM_ESC_END = 8'hDC;
	localparam logic [BYTE_W-1:0] SYM_ESC_ESC = 8'hDD;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_OVERFLOW = 2'd2,
		KIND_BAD_ESCAPE = 2'd3
	} sfd_kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} sfd_state_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic re;
		logic [ADDR_W-1:0] raddr;
	} sfd_mem_req_t;

endpackage

[src/sfd_ram.sv]
// Frame store: one write port, one registered read port.
module sfd_ram
	import sfd_pkg::*;
(
	input logic clk,
	input sfd_mem_req_t req,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

[src/sfd_ctrl.sv]
// Decoder control: byte decode, frame store access, drain sequencer, output register.
module sfd_ctrl
	import sfd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [BYTE_W-1:0] rx_byte,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [LEN_W-1:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [BYTE_W-1:0] data,
	output logic last,
	output logic [LEN_W-1:0] frame_length,
	output sfd_mem_req_t mem_req,
	input logic [BYTE_W-1:0] mem_rdata
);

	sfd_state_t state_q, state_d;
	logic esc_q, esc_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic [LEN_W-1:0] limit_q;
	logic [LEN_W-1:0] n_q, n_d;
	logic [LEN_W-1:0] rd_idx_q, rd_idx_d;
	logic rd_v_s1, rd_v_d;
	logic rd_last_s1, rd_last_d;

	logic out_valid_q, out_valid_d;
	sfd_kind_t kind_q, kind_d;
	logic [BYTE_W-1:0] data_q, data_d;
	logic last_q, last_d;
	logic [LEN_W-1:0] len_q, len_d;

	logic out_free, acc, adv, issue, full, do_store, res_v;
	logic [LEN_W-1:0] lim;
	logic [BYTE_W-1:0] sym;
	sfd_kind_t res_kind;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			esc_q <= 1'b0;
			cnt_q <= '0;
			rd_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			esc_q <= esc_d;
			cnt_q <= cnt_d;
			rd_v_s1 <= rd_v_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d;
		rd_idx_q <= rd_idx_d;
		rd_last_s1 <= rd_last_d;
		kind_q <= kind_d;
		data_q <= data_d;
		last_q <= last_d;
		len_q <= len_d;
	end

	always_comb begin
		state_d = state_q;
		esc_d = esc_q;
		cnt_d = cnt_q;
		n_d = n_q;
		rd_idx_d = rd_idx_q;
		rd_v_d = rd_v_s1;
		rd_last_d = rd_last_s1;
		out_valid_d = out_valid_q;
		kind_d = kind_q;
		data_d = data_q;
		last_d = last_q;
		len_d = len_q;
		mem_req = '0;
		do_store = 1'b0;
		res_v = 1'b0;
		res_kind = KIND_EMPTY;
		sym = rx_byte;

		out_free = !out_valid_q || out_ready;
		adv = rd_v_s1 && out_free;
		lim = (limit_q > DEPTH_LEN) ? DEPTH_LEN : limit_q;
		full = cnt_q >= lim;
		in_ready = 1'b0;
		issue = 1'b0;

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
				acc = in_valid && out_free;
				if (acc) begin
					if (esc_q) begin
						if (rx_byte == SYM_ESC_END) begin
							do_store = 1'b1;
							sym = SYM_END;
						end else if (rx_byte == SYM_ESC_ESC) begin
							do_store = 1'b1;
							sym = SYM_ESC;
						end else begin
							res_v = 1'b1;
							res_kind = KIND_BAD_ESCAPE;
							esc_d = 1'b0;
							cnt_d = '0;
						end
					end else if (rx_byte == SYM_END) begin
						cnt_d = '0;
						if (cnt_q == '0) begin
							res_v = 1'b1;
							res_kind = KIND_EMPTY;
						end else begin
							n_d = cnt_q;
							rd_idx_d = '0;
							state_d = ST_DRAIN;
						end
					end else if (rx_byte == SYM_ESC) begin
						esc_d = 1'b1;
					end else begin
						do_store = 1'b1;
					end

					if (do_store) begin
						esc_d = 1'b0;
						if (full) begin
							// drop the byte and restart reception
							res_v = 1'b1;
							res_kind = KIND_OVERFLOW;
							cnt_d = '0;
						end else begin
							mem_req.we = 1'b1;
							mem_req.waddr = cnt_q[ADDR_W-1:0];
							mem_req.wdata = sym;
							cnt_d = cnt_q + LEN_W'(1);
						end
					end

					if (res_v) begin
						out_valid_d = 1'b1;
						kind_d = res_kind;
						data_d = '0;
						last_d = 1'b1;
						len_d = '0;
					end
				end
			end
			ST_DRAIN: begin
				acc = 1'b0;
				issue = (rd_idx_q < n_q) && (!rd_v_s1 || adv);
				if (adv) begin
					out_valid_d = 1'b1;
					kind_d = KIND_BYTE;
					data_d = mem_rdata;
					last_d = rd_last_s1;
					len_d = n_q;
					rd_v_d = 1'b0;
					// stay until the last byte reaches the output register
					if (rd_last_s1) begin
						state_d = ST_IDLE;
					end
				end
				if (issue) begin
					mem_req.re = 1'b1;
					mem_req.raddr = rd_idx_q[ADDR_W-1:0];
					rd_v_d = 1'b1;
					rd_last_d = (rd_idx_q + LEN_W'(1)) == n_q;
					rd_idx_d = rd_idx_q + LEN_W'(1);
				end
			end
			default: begin
				acc = 1'b0;
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign data = data_q;
	assign last = last_q;
	assign frame_length = len_q;

endmodule

[src/slip_frame_decoder.sv]
// SLIP receive decoder top level: control plus frame store.
// A data or ESC byte gives no result; an error or
// empty frame result is valid the cycle after its byte transfers.
// An END closing an n-byte frame drains it through the store read port,
// one byte per cycle while the output is not stalled, set by the single frame store
// read port; input resumes after the last byte reaches the output register.
// Reset clears control state and sets the frame limit to 64; store contents are kept.
module slip_frame_decoder
	import sfd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [BYTE_W-1:0] rx_byte,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [LEN_W-1:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [BYTE_W-1:0] data,
	output logic last,
	output logic [LEN_W-1:0] frame_length
);

	sfd_mem_req_t mem_req;
	logic [BYTE_W-1:0] mem_rdata;

	sfd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data(data),
		.last(last),
		.frame_length(frame_length),
		.mem_req(mem_req),
		.mem_rdata(mem_rdata)
	);

	sfd_ram u_ram (
		.clk(clk),
		.req(mem_req),
		.rdata(mem_rdata)
	);

endmodule

[src/sfd_chk.sv]
// Port-level checker for the SLIP frame decoder, bound to the top level.
module sfd_chk
	import sfd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] kind,
	input logic [BYTE_W-1:0] data,
	input logic last,
	input logic [LEN_W-1:0] frame_length
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data)
			&& $stable(last) && $stable(frame_length))
		else $error("stalled result changed");

	a_non_byte_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_BYTE |-> last && data == '0 && frame_length == '0)
		else $error("error or empty result not a single zeroed item");

	a_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BYTE |-> frame_length != '0 && frame_length <= DEPTH_LEN)
		else $error("frame byte with bad length");

	// no input transfer while a frame is still draining
	a_no_rx_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BYTE && !last |-> !in_ready)
		else $error("input accepted mid-frame");

endmodule

bind slip_frame_decoder sfd_chk u_sfd_chk (.*);

[verif/tb_top.sv]
// Self-checking testbench for slip_frame_decoder: directed and random SLIP traffic.
module tb_top;
	import sfd_pkg::*;

	typedef struct {
		sfd_kind_t kind;
		logic [BYTE_W-1:0] data;
		logic last;
		logic [LEN_W-1:0] frame_length;
	} slip_result_t;

	class frame_scoreboard;
		logic [LEN_W-1:0] limit = LIMIT_RESET;
		bit esc_pending = 1'b0;
		int count = 0;
		logic [BYTE_W-1:0] store [STORE_DEPTH];
		slip_result_t due_results [$];
		int bytes_in = 0;
		int results_seen = 0;
		int errors = 0;
		int kind_seen [4] = '{0, 0, 0, 0};

		function void restart_rx();
			esc_pending = 1'b0;
			count = 0;
		endfunction

		function void add_result(sfd_kind_t k, logic [BYTE_W-1:0] d, logic l,
				logic [LEN_W-1:0] len);
			slip_result_t r;
			r.kind = k;
			r.data = d;
			r.last = l;
			r.frame_length = len;
			due_results.push_back(r);
		endfunction

		function void store_decoded(logic [BYTE_W-1:0] b);
			logic [LEN_W-1:0] eff;
			eff = (limit > DEPTH_LEN) ? DEPTH_LEN : limit;
			if (count >= int'(eff)) begin
				restart_rx();
				add_result(KIND_OVERFLOW, '0, 1'b1, '0);
			end else begin
				store[count] = b;
				count++;
				esc_pending = 1'b0;
			end
		endfunction

		// Work out the results of one accepted byte.
		function void decode_byte(logic [BYTE_W-1:0] b);
			int n;
			bytes_in++;
			if (esc_pending) begin
				if (b == SYM_ESC_END)
					store_decoded(SYM_END);
				else if (b == SYM_ESC_ESC)
					store_decoded(SYM_ESC);
				else begin
					restart_rx();
					add_result(KIND_BAD_ESCAPE, '0, 1'b1, '0);
				end
			end else if (b == SYM_END) begin
				n = count;
				restart_rx();
				if (n == 0)
					add_result(KIND_EMPTY, '0, 1'b1, '0);
				else
					for (int i = 0; i < n; i++)
						add_result(KIND_BYTE, store[i], (i == n - 1), LEN_W'(n));
			end else if (b == SYM_ESC) begin
				esc_pending = 1'b1;
			end else begin
				store_decoded(b);
			end
		endfunction

		function void check_result(slip_result_t got);
			slip_result_t want;
			results_seen++;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("t=%0t unexpected result: kind %0d data %02h last %0b len %0d",
						$time, got.kind, got.data, got.last, got.frame_length);
				return;
			end
			want = due_results.pop_front();
			kind_seen[want.kind]++;
			if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last ||
					got.frame_length !== want.frame_length) begin
				errors++;
				if (errors <= 10) begin
					$display("t=%0t mismatch: want kind %0d data %02h last %0b len %0d",
						$time, want.kind, want.data, want.last, want.frame_length);
					$display("           got kind %0d data %02h last %0b len %0d",
						got.kind, got.data, got.last, got.frame_length);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [BYTE_W-1:0] rx_byte;
	logic cfg_valid;
	logic cfg_ready;
	logic [LEN_W-1:0] cfg_data;
	logic out_valid;
	logic out_ready;
	logic [1:0] kind;
	logic [BYTE_W-1:0] data;
	logic last;
	logic [LEN_W-1:0] frame_length;

	frame_scoreboard sb = new;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	int holds_done = 0;
	int settings_used = 0;

	slip_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data(data),
		.last(last),
		.frame_length(frame_length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** slip_frame_decoder: FAILED **");
		$finish;
	end

	// One process observes every transfer so prediction always precedes checking.
	always @(posedge clk) begin : monitor
		slip_result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.limit = cfg_data;
			if (in_valid && in_ready)
				sb.decode_byte(rx_byte);
			if (out_valid && out_ready) begin
				got.kind = sfd_kind_t'(kind);
				got.data = data;
				got.last = last;
				got.frame_length = frame_length;
				sb.check_result(got);
			end
		end
	end

	initial begin : receiver
		int r;
		int stall_cycles;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				for (stall_cycles = 0; stall_cycles < 300; stall_cycles++)
					@(negedge clk);
				hold_req = 1'b0;
				holds_done++;
			end
			r = $urandom_range(0, 99);
			if (no_idle || r < 65)
				out_ready = 1'b1;
			else begin
				out_ready = 1'b0;
				if (r < 95)
					repeat ($urandom_range(1, 3)) @(negedge clk);
				else
					repeat ($urandom_range(10, 40)) @(negedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_byte = b;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_decoded(input logic [BYTE_W-1:0] b);
		if (b == SYM_END) begin
			send_byte(SYM_ESC);
			send_byte(SYM_ESC_END);
		end else if (b == SYM_ESC) begin
			send_byte(SYM_ESC);
			send_byte(SYM_ESC_ESC);
		end else
			send_byte(b);
	endtask

	task automatic send_frame(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				send_decoded(SYM_END);
			else if (r == 1)
				send_decoded(SYM_ESC);
			else
				send_decoded(BYTE_W'($urandom_range(0, 255)));
		end
		send_byte(SYM_END);
	endtask

	task automatic send_noise();
		int r;
		r = $urandom_range(0, 2);
		if (r == 0) begin
			send_byte(SYM_ESC);
			send_byte(BYTE_W'($urandom_range(0, 255)));
		end else if (r == 1) begin
			send_byte(SYM_ESC);
			send_byte(SYM_END);
		end else
			send_byte(BYTE_W'($urandom_range(0, 255)));
	endtask

	// Write only with the decoder drained; allow for a data byte still in flight.
	task automatic write_limit(input logic [LEN_W-1:0] v);
		in_valid = 1'b0;
		while (sb.due_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		settings_used++;
	endtask

	// Mostly well-formed frames, sized mostly small, some past the limit.
	task automatic run_random(input int budget);
		int first;
		int eff;
		int len;
		first = sb.bytes_in;
		while (sb.bytes_in - first < budget) begin
			eff = (sb.limit > DEPTH_LEN) ? STORE_DEPTH : int'(sb.limit);
			if ($urandom_range(0, 99) < 78) begin
				if ($urandom_range(0, 9) < 8)
					len = $urandom_range(0, (eff + 1 < 10) ? eff + 1 : 10);
				else
					len = $urandom_range(0, eff + 1);
				send_frame(len);
			end else
				send_noise();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty frame, extreme bytes, both escapes, bad escapes.
		send_byte(SYM_END);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYM_ESC);
		send_byte(SYM_ESC_END);
		send_byte(SYM_ESC);
		send_byte(SYM_ESC_ESC);
		send_byte(SYM_ESC_END);
		send_byte(SYM_END);
		send_byte(SYM_ESC);
		send_byte(8'h41);
		send_byte(SYM_ESC);
		send_byte(SYM_END);
		send_byte(SYM_ESC);
		send_byte(SYM_ESC);
		send_byte(8'h7E);
		send_byte(SYM_END);

		write_limit(7'd1);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(SYM_END);
		send_byte(8'h33);
		send_byte(SYM_END);

		write_limit(7'd0);
		send_byte(8'h44);
		send_byte(SYM_ESC);
		send_byte(SYM_ESC_END);
		send_byte(SYM_END);

		// Limit above the store depth: full frame, then one byte too many.
		write_limit(7'd127);
		send_frame(STORE_DEPTH);
		send_frame(STORE_DEPTH + 1);
		run_random(25);

		write_limit(7'd1);
		run_random(20);

		write_limit(7'd0);
		run_random(15);

		no_idle = 1'b1;
		write_limit(7'd5);
		run_random(25);
		no_idle = 1'b0;

		write_limit(LEN_W'($urandom_range(1, 64)));
		run_random(20);

		// Hold the output off while frames keep coming, so the input stalls.
		write_limit(7'd64);
		hold_req = 1'b1;
		run_random(40);

		in_valid = 1'b0;
		while (sb.due_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("Covered %0d bytes, %0d results, %0d limit writes, %0d output holds.",
			sb.bytes_in, sb.results_seen, settings_used, holds_done);
		$display("Kinds: %0d bytes, %0d empty, %0d overflow, %0d bad escape; %0d mismatches.",
			sb.kind_seen[KIND_BYTE], sb.kind_seen[KIND_EMPTY], sb.kind_seen[KIND_OVERFLOW],
			sb.kind_seen[KIND_BAD_ESCAPE], sb.errors);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("** slip_frame_decoder: PASSED **");
		else
			$display("** slip_frame_decoder: FAILED **");
		$finish;
	end

endmodule
